@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the lzw decoder rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is active
`define LZW_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lzw check failed");

// clocked check that also holds during reset
`define LZW_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("lzw check failed");

`endif

@@ rtl/core/lzw_pkg.sv @@
// ----------------------------------------------------------------------------
// lzw_pkg
// shared constants and types of the lzw variable width decoder
// ----------------------------------------------------------------------------
package lzw_pkg;

  localparam int MaxCodeBitsDef = 12;
  localparam int StringLimitDef = 512;
  localparam int CodeW          = 12;
  localparam int MinBits        = 9;

  localparam logic [CodeW-1:0] LzwClear = 12'd256;
  localparam logic [CodeW-1:0] LzwEod   = 12'd257;
  localparam logic [CodeW-1:0] LzwFirst = 12'd258;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEnd   = 2'd1;
  localparam logic [1:0] StRange = 2'd2;
  localparam logic [1:0] StTrunc = 2'd3;

  typedef struct packed {
    logic [CodeW-1:0] prev;
    logic [CodeW-1:0] len;
    logic [7:0]       val;
    logic [7:0]       first;
  } dict_entry_t;

endpackage

@@ rtl/core/lzw_dict.sv @@
// ----------------------------------------------------------------------------
// lzw_dict
// dictionary memory, one write and one registered read per cycle,
// literal entries supplied by logic
// ----------------------------------------------------------------------------
module lzw_dict import lzw_pkg::*; #(
  parameter int MaxCodeBits = MaxCodeBitsDef
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [MaxCodeBits-1:0] waddr_i,
  input  dict_entry_t            wdata_i,
  input  logic                   re_i,
  input  logic [MaxCodeBits-1:0] raddr_i,
  output dict_entry_t            rdata_o
);

  localparam int Depth = 1 << MaxCodeBits;

  dict_entry_t mem [Depth];
  dict_entry_t rd_q;
  logic        lit_q;
  logic [7:0]  lit_val_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q      <= mem[raddr_i];
      lit_q     <= (raddr_i < MaxCodeBits'(256));
      lit_val_q <= raddr_i[7:0];
    end
  end

  always_comb begin
    if (lit_q) begin
      rdata_o.prev  = '0;
      rdata_o.len   = CodeW'(1);
      rdata_o.val   = lit_val_q;
      rdata_o.first = lit_val_q;
    end else begin
      rdata_o = rd_q;
    end
  end

endmodule

@@ rtl/core/lzw_stack.sv @@
// ----------------------------------------------------------------------------
// lzw_stack
// string buffer memory, decoded bytes are written in reverse and read forward
// ----------------------------------------------------------------------------
module lzw_stack import lzw_pkg::*; #(
  parameter int StringLimit = StringLimitDef
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(StringLimit)-1:0] waddr_i,
  input  logic [7:0]                     wdata_i,
  input  logic                           re_i,
  input  logic [$clog2(StringLimit)-1:0] raddr_i,
  output logic [7:0]                     rdata_o
);

  logic [7:0] mem [StringLimit];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ rtl/core/lzw_variable_width_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder_unit
// lzw decoder, 9 to 12 bit codes packed msb first, strings out in 8 byte chunks
//
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_stall_o   data_byte_i
// out      out  out_valid_o / out_stall_i out_byte_0_o..7, byte_count_o,
//                                         last_chunk_o, status_o
// cfg      in   cfg_we_i                  cfg_wdata_i (early change)
//
// a byte that completes no code and a clear code are handled in the accepting state
// alone, an end or bad code is followed by one transfer in S_SEND
// a decoded code passes the update states S_RDC and S_UPD (skipped for a first
// code), the read setup state S_WSTART and the chain walk in S_WALK, then per
// 8 byte chunk the fill state S_FILL and S_SEND, which holds while stalled
// no clearing pass after reset, literal entries come from logic
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzw_variable_width_decoder_unit import lzw_pkg::*; #(
  parameter int MaxCodeBits = MaxCodeBitsDef,
  parameter int StringLimit = StringLimitDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_0_o,
  output logic [7:0] out_byte_1_o,
  output logic [7:0] out_byte_2_o,
  output logic [7:0] out_byte_3_o,
  output logic [7:0] out_byte_4_o,
  output logic [7:0] out_byte_5_o,
  output logic [7:0] out_byte_6_o,
  output logic [7:0] out_byte_7_o,
  output logic [3:0] byte_count_o,
  output logic       last_chunk_o,
  output logic [1:0] status_o
);

  localparam int AW = MaxCodeBits;
  localparam int SW = $clog2(StringLimit);
  localparam int NW = SW + 1;
  localparam logic [AW:0] TableSize = (AW+1)'(1) << MaxCodeBits;
  localparam logic [CodeW:0] LimitW = (CodeW+1)'(StringLimit);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDC    = 3'd1;
  localparam logic [2:0] S_UPD    = 3'd2;
  localparam logic [2:0] S_WSTART = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;
  localparam logic [2:0] S_SEND   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [23:0]      buf_q, buf_d;
  logic [4:0]       held_q, held_d;
  logic [3:0]       cw_q, cw_d;
  logic [AW:0]      nfc_q, nfc_d;
  logic [CodeW-1:0] prev_q, prev_d;
  logic             pv_q, pv_d;
  logic             ended_q, ended_d;
  logic             ec_q;
  logic [CodeW-1:0] code_q, code_d;
  logic [7:0]       pfirst_q, pfirst_d;
  logic [CodeW-1:0] plen_q, plen_d;
  logic [AW-1:0]    walk_c_q, walk_c_d;
  logic [CodeW-1:0] skip_q, skip_d;
  logic [SW-1:0]    idx_q, idx_d;
  logic [NW-1:0]    n_q, n_d;
  logic [NW-1:0]    base_q, base_d;
  logic [3:0]       fill_q, fill_d;
  logic [7:0]       out_q [8];
  logic [7:0]       out_d [8];
  logic [3:0]       cnt_q, cnt_d;
  logic             last_q, last_d;
  logic [1:0]       stat_q, stat_d;

  // bit unpacking
  logic [23:0]      buf_cat, code_full;
  logic [4:0]       held_sum, held_new;
  logic             have_code, take_in;
  logic [CodeW-1:0] code_w, code_mask;
  logic             code_bad;

  // walk setup
  logic [CodeW-1:0] set_len;
  logic [CodeW:0]   set_n;

  // chunk bookkeeping
  logic [NW-1:0]    rem;
  logic [3:0]       rem_cnt;
  logic [2:0]       cap_pos;

  dict_entry_t      d_rdata, d_wdata;
  logic             d_we, d_re;
  logic [AW-1:0]    d_waddr, d_raddr;
  logic             s_we, s_re;
  logic [SW-1:0]    s_raddr;
  logic [7:0]       s_rdata;
  logic [AW:0]      nfc_inc;
  logic [AW+1:0]    widen_sum;
  logic             flag_res;

  lzw_dict #(.MaxCodeBits(MaxCodeBits)) u_dict (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .re_i    (d_re),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  lzw_stack #(.StringLimit(StringLimit)) u_stack (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (idx_q),
    .wdata_i (d_rdata.val),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_SEND);
  assign take_in     = in_valid_i && (state_q == S_IDLE);

  assign buf_cat   = {buf_q[15:0], data_byte_i};
  assign held_sum  = held_q + 5'd8;
  assign have_code = (held_sum >= {1'b0, cw_q});
  assign held_new  = held_sum - {1'b0, cw_q};
  assign code_full = buf_cat >> held_new;
  assign code_mask = (CodeW'(1) << cw_q) - CodeW'(1);
  assign code_w    = code_full[CodeW-1:0] & code_mask;
  assign code_bad  = ({1'b0, code_w} > (CodeW+1)'(nfc_q)) ||
                     (({1'b0, code_w} == (CodeW+1)'(nfc_q)) && (nfc_q >= TableSize));

  assign rem     = n_q - base_q;
  assign rem_cnt = (rem > NW'(8)) ? 4'd8 : rem[3:0];
  assign cap_pos = 3'(fill_q - 4'd1);
  assign s_raddr = SW'(base_q + NW'(fill_q));
  assign s_re    = (state_q == S_FILL) && (fill_q < 4'd8);
  assign s_we    = (state_q == S_WALK) && (skip_q == '0);

  assign nfc_inc   = nfc_q + (AW+1)'(1);
  assign widen_sum = {1'b0, nfc_inc} + (AW+2)'(ec_q) + (AW+2)'(1);

  assign flag_res = out_valid_o && (status_o == StEnd || status_o == StRange);

  assign out_byte_0_o = out_q[0];
  assign out_byte_1_o = out_q[1];
  assign out_byte_2_o = out_q[2];
  assign out_byte_3_o = out_q[3];
  assign out_byte_4_o = out_q[4];
  assign out_byte_5_o = out_q[5];
  assign out_byte_6_o = out_q[6];
  assign out_byte_7_o = out_q[7];
  assign byte_count_o = cnt_q;
  assign last_chunk_o = last_q;
  assign status_o     = stat_q;

  always_comb begin
    d_re    = 1'b0;
    d_raddr = prev_q[AW-1:0];
    d_we    = 1'b0;
    d_waddr = nfc_q[AW-1:0];
    d_wdata.prev  = prev_q;
    d_wdata.first = pfirst_q;
    d_wdata.len   = plen_q + CodeW'(1);
    d_wdata.val   = ({1'b0, code_q} < (CodeW+1)'(nfc_q)) ? d_rdata.first : pfirst_q;
    case (state_q)
      S_IDLE: begin
        d_re = take_in;
      end
      S_RDC: begin
        d_re    = 1'b1;
        d_raddr = code_q[AW-1:0];
      end
      S_UPD: begin
        d_we = (nfc_q < TableSize);
      end
      S_WSTART: begin
        d_re    = 1'b1;
        d_raddr = walk_c_q;
      end
      S_WALK: begin
        d_re    = 1'b1;
        d_raddr = d_rdata.prev[AW-1:0];
      end
      default: begin
        d_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    set_len = CodeW'(1);
    if (state_q == S_UPD) begin
      set_len = ({1'b0, code_q} == (CodeW+1)'(nfc_q)) ? plen_q + CodeW'(1) : d_rdata.len;
    end
    if (set_len == '0) begin
      set_n = (CodeW+1)'(1);
    end else if ({1'b0, set_len} > LimitW) begin
      set_n = LimitW;
    end else begin
      set_n = {1'b0, set_len};
    end
  end

  always_comb begin
    state_d  = state_q;
    buf_d    = buf_q;
    held_d   = held_q;
    cw_d     = cw_q;
    nfc_d    = nfc_q;
    prev_d   = prev_q;
    pv_d     = pv_q;
    ended_d  = ended_q;
    code_d   = code_q;
    pfirst_d = pfirst_q;
    plen_d   = plen_q;
    walk_c_d = walk_c_q;
    skip_d   = skip_q;
    idx_d    = idx_q;
    n_d      = n_q;
    base_d   = base_q;
    fill_d   = fill_q;
    out_d    = out_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    stat_d   = stat_q;
    case (state_q)
      S_IDLE: begin
        if (take_in && !ended_q) begin
          if (!have_code) begin
            buf_d  = buf_cat;
            held_d = held_sum;
          end else begin
            buf_d  = buf_cat & ((24'h1 << held_new) - 24'h1);
            held_d = held_new;
            code_d = code_w;
            if (code_w == LzwEod) begin
              ended_d = 1'b1;
              for (int i = 0; i < 8; i++) out_d[i] = '0;
              cnt_d   = '0;
              last_d  = 1'b1;
              stat_d  = StEnd;
              state_d = S_SEND;
            end else if (code_w == LzwClear) begin
              cw_d  = 4'(MinBits);
              nfc_d = (AW+1)'(LzwFirst);
              pv_d  = 1'b0;
            end else if (!pv_q) begin
              if (code_w > CodeW'(255)) begin
                for (int i = 0; i < 8; i++) out_d[i] = '0;
                cnt_d   = '0;
                last_d  = 1'b1;
                stat_d  = StRange;
                state_d = S_SEND;
              end else begin
                prev_d   = code_w;
                pv_d     = 1'b1;
                walk_c_d = code_w[AW-1:0];
                skip_d   = '0;
                n_d      = NW'(1);
                idx_d    = '0;
                stat_d   = StOk;
                state_d  = S_WSTART;
              end
            end else if (code_bad) begin
              for (int i = 0; i < 8; i++) out_d[i] = '0;
              cnt_d   = '0;
              last_d  = 1'b1;
              stat_d  = StRange;
              state_d = S_SEND;
            end else begin
              state_d = S_RDC;
            end
          end
        end
      end
      S_RDC: begin
        pfirst_d = d_rdata.first;
        plen_d   = d_rdata.len;
        state_d  = S_UPD;
      end
      S_UPD: begin
        if (nfc_q < TableSize) begin
          nfc_d = nfc_inc;
          if (widen_sum > ((AW+2)'(1) << cw_q)) begin
            if (cw_q < 4'(MaxCodeBits)) cw_d = cw_q + 4'd1;
          end
        end
        prev_d   = code_q;
        walk_c_d = code_q[AW-1:0];
        n_d      = NW'(set_n);
        idx_d    = SW'(set_n - (CodeW+1)'(1));
        skip_d   = ({1'b0, set_len} > LimitW) ? CodeW'(set_len - CodeW'(StringLimit)) : '0;
        stat_d   = ({1'b0, set_len} > LimitW) ? StTrunc : StOk;
        state_d  = S_WSTART;
      end
      S_WSTART: begin
        state_d = S_WALK;
      end
      S_WALK: begin
        if (skip_q != '0) begin
          skip_d = skip_q - CodeW'(1);
        end else if (idx_q == '0) begin
          base_d  = '0;
          fill_d  = '0;
          for (int i = 0; i < 8; i++) out_d[i] = '0;
          state_d = S_FILL;
        end else begin
          idx_d = idx_q - SW'(1);
        end
      end
      S_FILL: begin
        if (fill_q != 4'd0) begin
          out_d[cap_pos] = ({1'b0, cap_pos} < rem_cnt) ? s_rdata : 8'd0;
        end
        if (fill_q == 4'd8) begin
          cnt_d   = rem_cnt;
          last_d  = (rem <= NW'(8));
          state_d = S_SEND;
        end else begin
          fill_d = fill_q + 4'd1;
        end
      end
      S_SEND: begin
        if (!out_stall_i) begin
          if (last_q) begin
            state_d = S_IDLE;
          end else begin
            base_d  = base_q + NW'(8);
            fill_d  = '0;
            for (int i = 0; i < 8; i++) out_d[i] = '0;
            state_d = S_FILL;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      buf_q   <= '0;
      held_q  <= '0;
      cw_q    <= 4'(MinBits);
      nfc_q   <= (AW+1)'(LzwFirst);
      prev_q  <= '0;
      pv_q    <= 1'b0;
      ended_q <= 1'b0;
      ec_q    <= 1'b1;
      skip_q  <= '0;
      idx_q   <= '0;
      n_q     <= '0;
      base_q  <= '0;
      fill_q  <= '0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
      stat_q  <= StOk;
    end else begin
      state_q <= state_d;
      buf_q   <= buf_d;
      held_q  <= held_d;
      cw_q    <= cw_d;
      nfc_q   <= nfc_d;
      prev_q  <= prev_d;
      pv_q    <= pv_d;
      ended_q <= ended_d;
      if (cfg_we_i) ec_q <= cfg_wdata_i;
      skip_q  <= skip_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      base_q  <= base_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      stat_q  <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q   <= code_d;
    pfirst_q <= pfirst_d;
    plen_q   <= plen_d;
    walk_c_q <= walk_c_d;
    out_q    <= out_d;
  end

  `LZW_ASSERT(a_count_range, clk_i, rst_ni, out_valid_o |-> (byte_count_o <= 4'd8))
  `LZW_ASSERT(a_single_result, clk_i, rst_ni, flag_res |-> (byte_count_o == 4'd0 && last_chunk_o))
  `LZW_ASSERT(a_width_range, clk_i, rst_ni, (cw_q >= 4'(MinBits)) && (cw_q <= 4'(MaxCodeBits)))
  `LZW_ASSERT(a_table_bound, clk_i, rst_ni, nfc_q <= TableSize)
  `LZW_ASSERT_ALWAYS(a_no_write_in_idle, clk_i, (state_q == S_IDLE) |-> !(d_we || s_we))

endmodule
